// File: rtl/ccp_pkg.sv
// Shared constants, types and arctangent table for the centred Cartesian-to-polar core.
package ccp_pkg;

   localparam int COORD_BITS    = 12;
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int STG_BITS      = $clog2(TABLE_LEN);

   localparam int FRAC_BITS = 14;
   localparam int XW        = COORD_BITS + FRAC_BITS + 3;
   localparam int XU        = XW - 1;
   localparam int ZW        = 28;

   localparam int GAIN_BITS = 30;
   localparam int LO_BITS   = 16;
   localparam int HI_BITS   = XU - LO_BITS;
   localparam int PLO_BITS  = LO_BITS + GAIN_BITS;
   localparam int PW        = XU + GAIN_BITS;
   localparam int MAG_SHIFT = 40;
   localparam int MAG_BITS  = 17;
   localparam int MAGW      = (PW - MAG_SHIFT > MAG_BITS) ? PW - MAG_SHIFT : MAG_BITS + 1;
   localparam int MAG_MAX   = 131071;

   localparam int ANG_BITS  = 16;
   localparam int ANG_SHIFT = 11;
   localparam int TW        = ZW - ANG_SHIFT;
   localparam int ANGLE_MAX = 25736;

   localparam logic [GAIN_BITS-1:0] GAIN   = GAIN_BITS'(652032874);
   localparam logic [ZW-1:0]        ANG_PI = ZW'(52707179);

   localparam logic [ZW-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331),
      ZW'(1047214), ZW'(524117), ZW'(262123), ZW'(131069),
      ZW'(65536), ZW'(32768), ZW'(16384), ZW'(8192),
      ZW'(4096), ZW'(2048), ZW'(1024), ZW'(512),
      ZW'(256), ZW'(128), ZW'(64), ZW'(32),
      ZW'(16), ZW'(8), ZW'(4), ZW'(2)
   };

   typedef enum logic {
      CSR_CENTRE_COL = 1'b0,
      CSR_CENTRE_ROW = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          zero;
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [ZW-1:0] z;
   } cordic_vec_type;

endpackage

// File: rtl/ccp_prep.sv
// Input stage: centre offset, left half plane pre-rotation and zero detection.
module ccp_prep
   import ccp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] centre_col,
   input  logic [COORD_BITS-1:0] centre_row,
   input  logic                  up_valid,
   input  logic [COORD_BITS-1:0] pixel_x,
   input  logic [COORD_BITS-1:0] pixel_y,
   output logic                  up_ready,
   output logic                  dn_valid,
   output cordic_vec_type        dn_vec,
   input  logic                  dn_ready
);

   logic                  valid_ff;
   cordic_vec_type        vec_ff;
   cordic_vec_type        vec_in;
   logic [COORD_BITS:0]   dx;
   logic [COORD_BITS:0]   dy;
   logic [XW-1:0]         x0;
   logic [XW-1:0]         y0;

   always_comb begin
      dx = {1'b0, pixel_x} - {1'b0, centre_col};
      dy = {1'b0, pixel_y} - {1'b0, centre_row};
      x0 = {{(XW - COORD_BITS - 1 - FRAC_BITS){dx[COORD_BITS]}}, dx, {FRAC_BITS{1'b0}}};
      y0 = {{(XW - COORD_BITS - 1 - FRAC_BITS){dy[COORD_BITS]}}, dy, {FRAC_BITS{1'b0}}};
      vec_in.zero = (dx == '0) && (dy == '0);
      if (dx[COORD_BITS]) begin
         vec_in.x = -x0;
         vec_in.y = -y0;
         vec_in.z = dy[COORD_BITS] ? -ANG_PI : ANG_PI;
      end else begin
         vec_in.x = x0;
         vec_in.y = y0;
         vec_in.z = '0;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;

endmodule

// File: rtl/ccp_cell.sv
// One CORDIC vectoring micro-rotation with its own pipeline register.
module ccp_cell
   import ccp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [STG_BITS-1:0] stage_idx,
   input  logic                up_valid,
   input  cordic_vec_type      up_vec,
   output logic                up_ready,
   output logic                dn_valid,
   output cordic_vec_type      dn_vec,
   input  logic                dn_ready
);

   logic                 valid_ff;
   cordic_vec_type       vec_ff;
   cordic_vec_type       vec_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   always_comb begin
      xs     = $signed(up_vec.x) >>> stage_idx;
      ys     = $signed(up_vec.y) >>> stage_idx;
      vec_in = up_vec;
      if (!up_vec.y[XW-1]) begin
         vec_in.x = up_vec.x + $unsigned(ys);
         vec_in.y = up_vec.y - $unsigned(xs);
         vec_in.z = up_vec.z + ATAN_TABLE[stage_idx];
      end else begin
         vec_in.x = up_vec.x - $unsigned(ys);
         vec_in.y = up_vec.y + $unsigned(xs);
         vec_in.z = up_vec.z - ATAN_TABLE[stage_idx];
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;

endmodule

// File: rtl/ccp_post.sv
// Output stages: gain compensation by split multiply, angle truncation and clamping.
module ccp_post
   import ccp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   input  cordic_vec_type             up_vec,
   output logic                       up_ready,
   output logic                       rsp_valid,
   output logic [MAG_BITS-1:0]        rsp_magnitude,
   output logic signed [ANG_BITS-1:0] rsp_angle,
   input  logic                       rsp_stall
);

   logic                valid_a_ff;
   logic [PLO_BITS-1:0] plo_ff;
   logic [PLO_BITS-1:0] plo_in;
   logic [HI_BITS-1:0]  hi_ff;
   logic [HI_BITS-1:0]  hi_in;
   logic [ANG_BITS-1:0] ang_ff;
   logic [ANG_BITS-1:0] ang_in;
   logic [XU-1:0]       xu;
   logic [ZW-1:0]       zabs;
   logic [TW-1:0]       tz;
   logic [TW-1:0]       tc;

   logic                valid_b_ff;
   logic [MAG_BITS-1:0] mag_ff;
   logic [MAG_BITS-1:0] mag_in;
   logic [ANG_BITS-1:0] ang_b_ff;
   logic [PW-1:0]       phi;
   logic [PW-1:0]       prod;
   logic [MAGW-1:0]     magfull;
   logic                ready_a;
   logic                ready_b;

   always_comb begin
      xu = (up_vec.x[XW-1] || up_vec.zero) ? '0 : up_vec.x[XU-1:0];
      plo_in = PLO_BITS'(xu[LO_BITS-1:0]) * PLO_BITS'(GAIN);
      hi_in  = xu[XU-1:LO_BITS];
      zabs   = up_vec.z[ZW-1] ? -up_vec.z : up_vec.z;
      tz     = zabs[ZW-1:ANG_SHIFT];
      tc     = (tz > TW'(ANGLE_MAX)) ? TW'(ANGLE_MAX) : tz;
      if (up_vec.zero) begin
         ang_in = '0;
      end else if (up_vec.z[ZW-1]) begin
         ang_in = -tc[ANG_BITS-1:0];
      end else begin
         ang_in = tc[ANG_BITS-1:0];
      end
   end

   always_comb begin
      phi     = PW'(hi_ff) * PW'(GAIN);
      prod    = (phi << LO_BITS) + PW'(plo_ff);
      magfull = MAGW'(prod >> MAG_SHIFT);
      mag_in  = (magfull > MAGW'(MAG_MAX)) ? MAG_BITS'(MAG_MAX) : magfull[MAG_BITS-1:0];
   end

   assign ready_b  = !valid_b_ff || !rsp_stall;
   assign ready_a  = !valid_a_ff || ready_b;
   assign up_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= up_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
      if (ready_a && up_valid) begin
         plo_ff <= plo_in;
         hi_ff  <= hi_in;
         ang_ff <= ang_in;
      end
      if (ready_b && valid_a_ff) begin
         mag_ff   <= mag_in;
         ang_b_ff <= ang_ff;
      end
   end

   assign rsp_valid     = valid_b_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_angle     = $signed(ang_b_ff);

endmodule

// File: rtl/centred_cartesian_to_polar_core.sv
// Top level of the centred Cartesian-to-polar core with its centre registers.
// An accepted beat passes one input stage, one cell per CORDIC micro-rotation and two
// gain and output stages. Throughput is one beat per cycle while rsp_stall is low;
// every register stage advances while the one after it is empty or moving, so a
// stalled result only holds back beats queued directly behind it.
// Synchronous active-high reset empties the pipeline and sets the centre to (320, 240).
module centred_cartesian_to_polar_core
   import ccp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [COORD_BITS-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_BITS-1:0]      req_pixel_x,
   input  logic [COORD_BITS-1:0]      req_pixel_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [MAG_BITS-1:0]        rsp_magnitude,
   output logic signed [ANG_BITS-1:0] rsp_angle
);

   logic [COORD_BITS-1:0] centre_col_ff;
   logic [COORD_BITS-1:0] centre_row_ff;
   logic                  prep_ready;

   logic           link_valid [0:NUM_STAGES];
   logic           link_ready [0:NUM_STAGES];
   cordic_vec_type link_vec   [0:NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_col_ff <= COORD_BITS'(320);
         centre_row_ff <= COORD_BITS'(240);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTRE_COL: centre_col_ff <= csr_wdata;
            CSR_CENTRE_ROW: centre_row_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ccp_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .centre_col (centre_col_ff),
      .centre_row (centre_row_ff),
      .up_valid   (req_valid),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .up_ready   (prep_ready),
      .dn_valid   (link_valid[0]),
      .dn_vec     (link_vec[0]),
      .dn_ready   (link_ready[0])
   );

   assign req_stall = !prep_ready;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      ccp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STG_BITS'(g)),
         .up_valid  (link_valid[g]),
         .up_vec    (link_vec[g]),
         .up_ready  (link_ready[g]),
         .dn_valid  (link_valid[g+1]),
         .dn_vec    (link_vec[g+1]),
         .dn_ready  (link_ready[g+1])
      );
   end

   ccp_post u_post (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (link_valid[NUM_STAGES]),
      .up_vec        (link_vec[NUM_STAGES]),
      .up_ready      (link_ready[NUM_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle),
      .rsp_stall     (rsp_stall)
   );

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_angle) <= ANGLE_MAX) && (int'(rsp_angle) >= -ANGLE_MAX))
      else $error("Result angle is outside the range of minus pi to pi.");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> link_valid[0] && !link_ready[0])
      else $error("Input is stalled while the input stage can move.");

   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("A result beat is shown right after reset.");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the centred Cartesian-to-polar core: directed and random beats.
`timescale 1ns / 100ps

module tb;
   import ccp_pkg::*;

   localparam int ROT_STAGES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
   localparam int LATENCY    = ROT_STAGES + 3;
   localparam int DRAIN      = 2 * LATENCY + 10;
   localparam int PIX_MAX    = (1 << COORD_BITS) - 1;
   localparam int CYCLE_CAP  = 200000;
   localparam longint PI_Q24   = 52707179;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint ANG_LIM  = 25736;
   localparam longint MAG_LIM  = 131071;
   localparam longint ARCTAN_Q24 [0:23] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } pixel_type;

   typedef struct packed {
      logic [MAG_BITS-1:0]        mag;
      logic signed [ANG_BITS-1:0] ang;
   } polar_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic                       csr_index = CSR_CENTRE_COL;
   logic [COORD_BITS-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [COORD_BITS-1:0]      req_pixel_x = '0;
   logic [COORD_BITS-1:0]      req_pixel_y = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [MAG_BITS-1:0]        rsp_magnitude;
   logic signed [ANG_BITS-1:0] rsp_angle;

   pixel_type pixel_queue[$];
   polar_type expected_polar[$];
   logic [COORD_BITS-1:0] centre_col_q = 12'd320;
   logic [COORD_BITS-1:0] centre_row_q = 12'd240;
   logic req_taken = 1'b0;
   logic calm = 1'b0;
   int   cycles = 0;
   int   beats_taken = 0;
   int   results_checked = 0;
   int   mismatches = 0;
   int   settings_used = 1;

   centred_cartesian_to_polar_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic polar_type polar_of(input logic [COORD_BITS-1:0] px, py,
                                          input logic [COORD_BITS-1:0] ccol, crow);
      longint dx, dy, x, y, z, xs, ys, m, t, a;
      polar_type res;
      dx = longint'(px) - longint'(ccol);
      dy = longint'(py) - longint'(crow);
      res.mag = '0;
      res.ang = '0;
      if (dx == 0 && dy == 0) return res;
      x = dx * 16384;
      y = dy * 16384;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q24 : -PI_Q24;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_Q24[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_Q24[i];
         end
      end
      if (x < 0) x = 0;
      m = (x * GAIN_Q30) >>> 40;
      if (m > MAG_LIM) m = MAG_LIM;
      t = ((z >= 0) ? z : -z) >> 11;
      a = (z >= 0) ? t : -t;
      if (a > ANG_LIM) a = ANG_LIM;
      if (a < -ANG_LIM) a = -ANG_LIM;
      res.mag = m[MAG_BITS-1:0];
      res.ang = a[ANG_BITS-1:0];
      return res;
   endfunction

   function automatic logic [COORD_BITS-1:0] to_pixel(input int v);
      if (v < 0) return '0;
      if (v > PIX_MAX) return PIX_MAX[COORD_BITS-1:0];
      return v[COORD_BITS-1:0];
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
         if (!req_valid || req_taken) begin
            if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
               req_valid   <= 1'b1;
               req_pixel_x <= pixel_queue[0].x;
               req_pixel_y <= pixel_queue[0].y;
               void'(pixel_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      polar_type got;
      polar_type want;
      cycles <= cycles + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_we) begin
            if (csr_index == CSR_CENTRE_COL) centre_col_q <= csr_wdata;
            else centre_row_q <= csr_wdata;
         end
         if (req_valid && !req_stall) begin
            expected_polar.push_back(polar_of(req_pixel_x, req_pixel_y,
                                              centre_col_q, centre_row_q));
            beats_taken <= beats_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.mag = rsp_magnitude;
            got.ang = rsp_angle;
            if (expected_polar.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result: mag %0d angle %0d", got.mag, got.ang);
            end else begin
               want = expected_polar.pop_front();
               results_checked <= results_checked + 1;
               if (got.mag !== want.mag || got.ang !== want.ang) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: mag %0d expected %0d, angle %0d expected %0d",
                              got.mag, want.mag, got.ang, want.ang);
               end
            end
         end
      end
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("centred_cartesian_to_polar_core verification failed");
         $finish;
      end
   end

   task automatic wait_quiet();
      while (pixel_queue.size() != 0 || req_valid || expected_polar.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_centre(input logic [COORD_BITS-1:0] col, row);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTRE_COL;
      csr_wdata <= col;
      @(negedge clock);
      csr_index <= CSR_CENTRE_ROW;
      csr_wdata <= row;
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic add_pixel(input int x, y);
      pixel_type p;
      p.x = to_pixel(x);
      p.y = to_pixel(y);
      pixel_queue.push_back(p);
   endtask

   task automatic add_random_pixels(input int count);
      int sel;
      int cx;
      int cy;
      cx = int'(centre_col_q);
      cy = int'(centre_row_q);
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 60)
            add_pixel($urandom_range(PIX_MAX), $urandom_range(PIX_MAX));
         else if (sel < 85)
            add_pixel(cx + $urandom_range(16) - 8, cy + $urandom_range(16) - 8);
         else if (sel < 93)
            add_pixel($urandom_range(PIX_MAX), cy);
         else
            add_pixel(cx, $urandom_range(PIX_MAX));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset centre: zero offset, both axes in both directions, the corners and near-centre offsets.
      add_pixel(320, 240);
      add_pixel(0, 240);
      add_pixel(4095, 240);
      add_pixel(320, 0);
      add_pixel(320, 4095);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      add_pixel(4095, 0);
      add_pixel(319, 240);
      add_pixel(321, 241);
      add_pixel(319, 239);
      add_pixel(321, 239);
      add_pixel(0, 239);
      wait_quiet();

      set_centre(12'd0, 12'd0);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(4095, 0);
      add_pixel(0, 4095);
      wait_quiet();

      set_centre(12'hFFF, 12'hFFF);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      wait_quiet();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_centre(12'd320, 12'd240);
            1: set_centre(12'd2048, 12'd2048);
            2: set_centre(12'd0, 12'd2048);
            4: set_centre(12'hFFF, 12'd0);
            5: set_centre(COORD_BITS'($urandom_range(PIX_MAX)),
                          COORD_BITS'($urandom_range(PIX_MAX)));
            default: set_centre(COORD_BITS'($urandom_range(2048)),
                                COORD_BITS'($urandom_range(2048)));
         endcase
         calm = (phase == 3);
         add_random_pixels(100);
         wait_quiet();
      end
      calm = 1'b0;

      if (expected_polar.size() != 0) mismatches += expected_polar.size();
      $display("%0d beats checked against the predictor over %0d centre settings",
               results_checked, settings_used);
      $display("%0d beats accepted, %0d mismatches", beats_taken, mismatches);
      if (mismatches == 0) begin
         $display("centred_cartesian_to_polar_core verification clean");
      end else begin
         $display("centred_cartesian_to_polar_core verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/ccp_pkg.sv
rtl/ccp_prep.sv
rtl/ccp_cell.sv
rtl/ccp_post.sv
rtl/centred_cartesian_to_polar_core.sv
bench/tb.sv
